// ----- src/qph_pkg.sv -----
package qph_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int SLOT_W     = 5;
    localparam int STAT_W     = 2;
    localparam int DIGIT_W    = 8;
    localparam int RED_CYCLES = 4;
    localparam int RED_W      = RED_CYCLES * DIGIT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STAT_W-1:0] ST_USED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_GONE  = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
    } t_entry;

    typedef struct packed {
        logic              load;
        logic              red_step;
        logic              pos_init;
        logic              pos_adv;
        logic              clr_adv;
        logic              wr_en;
        logic [STAT_W-1:0] wr_status;
        logic              res_load;
        logic              res_hit;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STAT_W-1:0] rd_status;
        logic              key_eq;
    } t_sts;

endpackage

// ----- src/qph_ctrl.sv -----
module qph_ctrl #(
    parameter int TABLE_SIZE = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output qph_pkg::t_cmd  o_cmd,
    input  qph_pkg::t_sts  i_sts
);
    import qph_pkg::*;

    localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = (SW > 2) ? SW : 2;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    logic          last_probe;
    logic          found;

    assign last_probe = (r_cnt == CW'(TABLE_SIZE - 1));
    assign found      = (i_sts.rd_status == ST_USED) && i_sts.key_eq;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_status = ST_EMPTY;
                o_cmd.clr_adv   = 1'b1;
                n_cnt           = r_cnt + CW'(1);
                if (last_probe) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(RED_CYCLES - 1)) begin
                    n_cnt = '0;
                    if (i_sts.op == OP_INSERT || i_sts.op == OP_SEARCH ||
                        i_sts.op == OP_DELETE) begin
                        n_state = S_ISSUE;
                    end else begin
                        // unused opcode: fail without touching the table
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_hit  = 1'b0;
                        n_state        = S_RESULT;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.pos_init = 1'b1;
                n_state        = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.op == OP_INSERT) begin
                    if (i_sts.rd_status != ST_USED) begin
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_status = ST_USED;
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_hit   = 1'b1;
                        n_state         = S_RESULT;
                    end else if (last_probe) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_RESULT;
                    end else begin
                        o_cmd.pos_adv = 1'b1;
                        n_cnt         = r_cnt + CW'(1);
                    end
                end else begin
                    if (found) begin
                        // leave a tombstone so later chains stay reachable
                        o_cmd.wr_en     = (i_sts.op == OP_DELETE);
                        o_cmd.wr_status = ST_GONE;
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_hit   = 1'b1;
                        n_state         = S_RESULT;
                    end else if (i_sts.rd_status == ST_EMPTY || last_probe) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_RESULT;
                    end else begin
                        o_cmd.pos_adv = 1'b1;
                        n_cnt         = r_cnt + CW'(1);
                    end
                end
            end
            S_RESULT: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (r_state == S_CLEAR || r_state == S_PROBE))
        else $error("table write outside clear or probe");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> r_cnt <= CW'(TABLE_SIZE - 1))
        else $error("probe count past table size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> r_state == S_RESULT)
        else $error("result captured without entering result state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_valid && r_state == S_IDLE))
        else $error("output load did not raise valid");

endmodule

// ----- src/qph_dp.sv -----
module qph_dp #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qph_pkg::t_cmd                 i_cmd,
    output qph_pkg::t_sts                 o_sts,
    input  logic [qph_pkg::OP_W-1:0]      i_operation,
    input  logic [qph_pkg::KEY_W-1:0]     i_key,
    output logic                          o_status,
    output logic [qph_pkg::SLOT_W-1:0]    o_slot
);
    import qph_pkg::*;

    localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [SW:0]   NV  = (SW+1)'(TABLE_SIZE);
    localparam logic [SW-1:0] C10 = SW'(10 % TABLE_SIZE);
    localparam logic [SW-1:0] C3  = SW'(3 % TABLE_SIZE);
    localparam logic [SW-1:0] C2  = SW'(2 % TABLE_SIZE);

    t_entry              r_mem [TABLE_SIZE];
    t_entry              r_rd_entry;
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [RED_W-1:0]    r_red_sh;
    logic [SW-1:0]       r_rem, n_rem;
    logic [SW-1:0]       r_pos, n_pos;
    logic [SW-1:0]       r_step, n_step;
    logic [SW-1:0]       r_res_slot;
    logic                r_res_hit;
    logic                r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [SW:0]         red_t;
    logic [SW:0]         st_t;
    logic [SW:0]         ad_t;
    logic [SW:0]         sp_t;
    logic [SW-1:0]       start_pos;
    logic [SW-1:0]       adv_pos;
    logic [SW-1:0]       adv_step;

    // fold one key digit into the running remainder, one bit per step
    always_comb begin
        n_rem = r_rem;
        red_t = '0;
        for (int b = 0; b < DIGIT_W; b++) begin
            red_t = {n_rem, r_red_sh[RED_W-1-b]};
            if (red_t >= NV) begin
                red_t = red_t - NV;
            end
            n_rem = red_t[SW-1:0];
        end
    end

    always_comb begin
        st_t = (SW+1)'(r_rem) + (SW+1)'(C10);
        if (st_t >= NV) begin
            st_t = st_t - NV;
        end
        start_pos = st_t[SW-1:0];

        // successive quadratic offsets differ by 2i+3
        ad_t = (SW+1)'(r_pos) + (SW+1)'(r_step);
        if (ad_t >= NV) begin
            ad_t = ad_t - NV;
        end
        adv_pos = ad_t[SW-1:0];

        sp_t = (SW+1)'(r_step) + (SW+1)'(C2);
        if (sp_t >= NV) begin
            sp_t = sp_t - NV;
        end
        adv_step = sp_t[SW-1:0];
    end

    always_comb begin
        n_pos  = r_pos;
        n_step = r_step;
        if (i_cmd.clr_adv) begin
            n_pos = r_pos + SW'(1);
        end else if (i_cmd.pos_init) begin
            n_pos  = start_pos;
            n_step = C3;
        end else if (i_cmd.pos_adv) begin
            n_pos  = adv_pos;
            n_step = adv_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_key    <= i_key;
            r_red_sh <= RED_W'(i_key);
            r_rem    <= '0;
        end else if (i_cmd.red_step) begin
            r_red_sh <= r_red_sh << DIGIT_W;
            r_rem    <= n_rem;
        end
        if (i_cmd.res_load) begin
            r_res_hit  <= i_cmd.res_hit;
            r_res_slot <= r_pos;
        end
        if (i_cmd.out_load) begin
            r_out_status <= !r_res_hit;
            r_out_slot   <= r_res_hit ? SLOT_W'(r_res_slot) : '0;
        end
    end

    // table store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_pos] <= '{status: i_cmd.wr_status, key: r_key};
        end
        r_rd_entry <= r_mem[n_pos];
    end

    assign o_sts.op        = r_op;
    assign o_sts.rd_status = r_rd_entry.status;
    assign o_sts.key_eq    = (r_rd_entry.key == r_key);
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;

endmodule

// ----- src/quadratic_probe_hash_table_top.sv -----
// Operation: an accepted request runs key reduction, one 8-bit key digit at a time, then probes
// p slots, p = probes used (1..TABLE_SIZE); an unused operation code skips the probes.
// A new request is taken only in idle, once the previous result has been loaded into the
// output register, which waits while the output is stalled; the table is read once per probe.
// Reset: synchronous, active low; a clearing pass then marks every slot empty,
// one slot a cycle, with input ready held low meanwhile.
module quadratic_probe_hash_table_top #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qph_pkg::OP_W-1:0]      i_operation,
    input  logic [qph_pkg::KEY_W-1:0]     i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic [qph_pkg::SLOT_W-1:0]    o_slot
);
    import qph_pkg::*;

    t_cmd cmd;
    t_sts sts;

    qph_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    qph_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

endmodule

// ----- test/qph_checker.sv -----
`timescale 1ns / 1ps
module qph_checker
    import qph_pkg::*;
#(
    parameter int TABLE_SIZE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [KEY_W-1:0]  i_key,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_status,
    input  logic [SLOT_W-1:0] i_slot,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_misses
);

    localparam logic RES_OK   = 1'b0;
    localparam logic RES_MISS = 1'b1;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
    } t_answer;

    logic [KEY_W-1:0]  slot_key   [TABLE_SIZE];
    logic [STAT_W-1:0] slot_state [TABLE_SIZE];
    t_answer           answers_due [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        o_fail_count++;
    endtask

    // Walk the quadratic probe path, update the table and return the answer.
    function automatic t_answer apply_request(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] k);
        t_answer           ans;
        logic [KEY_W:0]    step;
        logic [KEY_W:0]    sum;
        logic [SLOT_W-1:0] pos;
        ans = '{RES_MISS, '0};
        for (int n = 0; n < TABLE_SIZE; n++) begin
            step = 10 + 2 * n + n * n;
            sum  = {1'b0, k} + step;
            pos  = SLOT_W'(sum % TABLE_SIZE);
            if (op == OP_INSERT) begin
                if (slot_state[pos] != ST_USED) begin
                    slot_key[pos]   = k;
                    slot_state[pos] = ST_USED;
                    ans = '{RES_OK, pos};
                    break;
                end
            end else if (op == OP_SEARCH || op == OP_DELETE) begin
                if (slot_state[pos] == ST_USED && slot_key[pos] == k) begin
                    // leave a tombstone so later chains stay reachable
                    if (op == OP_DELETE) slot_state[pos] = ST_GONE;
                    ans = '{RES_OK, pos};
                    break;
                end
                if (slot_state[pos] == ST_EMPTY) break;
            end else begin
                break;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer due;
        if (!i_rst_n) begin
            foreach (slot_state[n]) slot_state[n] = ST_EMPTY;
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (i_status) o_misses++;
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: status %0d slot %0d",
                                              i_status, i_slot));
                end else begin
                    due = answers_due.pop_front();
                    if (i_status !== due.status)
                        report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                                  due.status, i_status));
                    if (i_slot !== due.slot)
                        report_mismatch($sformatf("slot mismatch: expected %0d, got %0d",
                                                  due.slot, i_slot));
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(apply_request(i_operation, i_key));
        end
        o_pending <= answers_due.size();
    end

endmodule

// ----- test/tb_quadratic_probe_hash_table_top.sv -----
`timescale 1ns / 1ps
module tb_quadratic_probe_hash_table_top;
    import qph_pkg::*;

    localparam int               TABLE_SIZE   = 32;
    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX      = '1;
    localparam int               POOL_SIZE    = 20;
    localparam int               STALL_LIMIT  = 4000;
    localparam int               LONG_HOLD    = 400;
    localparam int               DRAIN_CYCLES = 60;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [OP_W-1:0]   i_operation;
    logic [KEY_W-1:0]  i_key;
    logic              o_valid;
    logic              i_ready;
    logic              o_status;
    logic [SLOT_W-1:0] o_slot;

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;
    int miss_cnt;

    int               tx_idle_pct;
    int               rx_stall_pct;
    bit               long_hold_go;
    bit               long_hold_done;
    int               hold_left;
    int               quiet_cycles;
    int               op_seen [4];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    quadratic_probe_hash_table_top #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

    qph_checker #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_status     (o_status),
        .i_slot       (o_slot),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt),
        .o_checked    (checked_cnt),
        .o_misses     (miss_cnt)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (long_hold_go && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no item accepted for %0d cycles", $time, STALL_LIMIT);
            $display("quadratic_probe_hash_table_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= k;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        op_seen[op]++;
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        int               roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 45)      op = OP_INSERT;
            else if (roll < 70) op = OP_SEARCH;
            else if (roll < 95) op = OP_DELETE;
            else                op = OP_UNUSED;
            // mostly pool keys so searches and deletes hit and chains collide
            if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
            else                         k = KEY_W'($urandom);
            send_item(op, k);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_random(count);
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_INSERT;
        i_key          = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        long_hold_go   = 1'b0;
        foreach (op_seen[n]) op_seen[n] = 0;
        foreach (key_pool[n]) begin
            key_pool[n] = KEY_W'($urandom);
            if (n % 2 == 0) key_pool[n][4:0] = 5'($urandom_range(3));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: key extremes, duplicates, tombstones, unused code, full probe path
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_SEARCH, '0);
        send_item(OP_SEARCH, KEY_MAX);
        send_item(OP_SEARCH, 31'd1);
        send_item(OP_INSERT, '0);
        send_item(OP_DELETE, '0);
        send_item(OP_SEARCH, '0);
        send_item(OP_INSERT, '0);
        send_item(OP_DELETE, 31'd12345);
        send_item(OP_UNUSED, KEY_MAX);
        send_item(OP_UNUSED, '0);
        repeat (9) send_item(OP_INSERT, 31'd5);
        send_item(OP_SEARCH, 31'd5);
        send_item(OP_DELETE, 31'd5);
        send_item(OP_DELETE, KEY_MAX);
        send_item(OP_SEARCH, KEY_MAX);
        wait_drained();

        run_phase(0, 0, 350);
        run_phase(59, 0, 350);
        run_phase(0, 59, 350);
        run_phase(13, 13, 310);

        // back-to-back items against a long output stall
        long_hold_go = 1'b1;
        run_phase(0, 0, 40);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d inserts, %0d searches, %0d deletes, %0d unused codes:",
                 op_seen[OP_INSERT], op_seen[OP_SEARCH], op_seen[OP_DELETE],
                 op_seen[OP_UNUSED]);
        $display("directed cases, four idle mixes, a long output stall; %0d results, %0d misses.",
                 checked_cnt, miss_cnt);
        if (fail_cnt == 0) begin
            $display("quadratic_probe_hash_table_top verification clean");
        end else begin
            $display("quadratic_probe_hash_table_top verification failed");
        end
        $finish;
    end

endmodule
